// ===== rtl/core/bls_pkg.sv =====
// Package for the bounded list store: command and status codes, port field widths,
// default parameters and the control and status structs between controller and datapath.
// Depends on nothing.
package bls_pkg;

	localparam int DEPTH_DEF       = 64;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam int CMD_W     = 3;
	localparam int VALUE_W   = 32;
	localparam int POS_W     = 6;
	localparam int LEN_W     = 7;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 7;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 48;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 3'd0,
		CMD_POP    = 3'd1,
		CMD_READ   = 3'd2,
		CMD_FIND   = 3'd3,
		CMD_ERASE  = 3'd4,
		CMD_REMOVE = 3'd5,
		CMD_CLEAR  = 3'd6
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RDWAIT,
		S_SCAN,
		S_SHIFT,
		S_REPLY
	} state_t;

	typedef struct packed {
		logic    load_in;     // latch the accepted word, clear the result
		logic    push_wr;     // write value at the tail, count up
		logic    pop_rd;      // read the last entry, count down
		logic    pos_rd;      // read the entry at position
		logic    scan_init;   // walk pointer to zero
		logic    scan_run;    // one step of the search walk
		logic    erase_init;  // walk pointer to position plus length
		logic    remove_init; // walk pointer past the match, length one
		logic    shift_run;   // one step of the move-down walk
		logic    cnt_to_pos;  // truncate count to position
		logic    cnt_to_chk;  // truncate count to the matched index
		logic    cnt_clear;
		logic    cnt_sub;     // count minus length
		logic    take_rv;
		logic    take_fp;
		logic    set_st;
		status_t st;
		logic    out_load;
	} bls_ctrl_t;

	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic empty;
		logic pos_in;      // position below count
		logic erase_tail;  // erase run reaches the tail
		logic len_zero;
		logic match;       // entry under test equals value
		logic match_last;  // matched entry is the last one
		logic walk_done;   // walk exhausted, nothing in flight
		logic out_free;
	} bls_stat_t;

endpackage

// ===== rtl/core/bounded_list_store_unit.sv =====
// Bounded list store, top level: stream ports, controller and datapath.
// Depends on bls_pkg, bls_ctrl and bls_datapath.
//
// The block keeps an ordered list of up to DEPTH words in a single-port-read,
// single-port-write memory and takes one command word at a time on the slave
// stream; each command yields exactly one result word on the master stream.
// From acceptance to the result entering the output register: push, clear,
// failed commands and erases that only truncate or have length zero go from
// decode straight to reply; pop and read pass a read wait state; find walks
// the entries up to the match, or all of them when there is none; erase moves
// down the entries behind the erased run; remove takes its search plus the
// move-down of the entries behind the match, with no move-down when the match
// is the last entry. The reply may wait for the output register to free.
// The walks run at one entry per cycle, set by the one memory read port with
// its registered read data. A new command is accepted
// once the previous result has been handed to the output register, even while
// that result still waits for m_tready. Entries hold no reset value: reset
// clears the count, walk flag and output valid only, so no clearing pass runs.
module bounded_list_store_unit #(
	parameter int DEPTH       = bls_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = bls_pkg::VALUE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// s_tdata, from bit 0: value[31:0], position[37:32], erase_length[44:38], zero pad
	input  logic [bls_pkg::IN_TDATA_W-1:0]  s_tdata,
	// s_tuser: command[2:0]
	input  logic [bls_pkg::CMD_W-1:0]       s_tuser,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// m_tdata, from bit 0: read_value[31:0], found_position[37:32], status[39:38],
	// entry_count[46:40], zero pad
	output logic [bls_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready
);
	import bls_pkg::*;

	bls_ctrl_t                ctrl;
	bls_stat_t                stat;
	logic [VALUE_W-1:0]       res_value;
	logic [POS_W-1:0]         res_pos;
	status_t                  res_status;
	logic [COUNT_W-1:0]       res_count;

	// Sequence each command word through decode, walk and reply.
	bls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	// Unpack the command word straight into the datapath input latches.
	bls_datapath #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctrl               (ctrl),
		.stat               (stat),
		.in_cmd             (cmd_t'(s_tuser)),
		.in_value           (s_tdata[31:0]),
		.in_position        (s_tdata[37:32]),
		.in_erase_length    (s_tdata[44:38]),
		.out_ready          (m_tready),
		.out_valid          (m_tvalid),
		.out_read_value     (res_value),
		.out_found_position (res_pos),
		.out_status         (res_status),
		.out_entry_count    (res_count)
	);

	// Pack the result word, pad the top bit with a zero.
	assign m_tdata = {1'b0, res_count, res_status, res_pos, res_value};

	// One command at a time: after a word is taken, hold off until it has replied.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command accepted while another is in progress");

	// Never load a result over one that the sink has not yet taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> (!m_tvalid || m_tready))
		else $error("result register overwritten while still waiting");

	// The memory read port serves one requester per cycle.
	a_one_reader: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctrl.pop_rd, ctrl.pos_rd, ctrl.scan_run, ctrl.shift_run}))
		else $error("more than one memory read requested");

	// No result is loaded in the decode step that follows acceptance of a word.
	a_load_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !ctrl.out_load)
		else $error("result loaded in the cycle after acceptance");

endmodule

// ===== rtl/core/bls_datapath.sv =====
// Datapath of the bounded list store: entry memory, count, walk pointer and
// output register. Driven by bls_ctrl; depends on bls_pkg.
module bls_datapath #(
	parameter int DEPTH       = bls_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = bls_pkg::VALUE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bls_pkg::bls_ctrl_t          ctrl,
	output bls_pkg::bls_stat_t          stat,
	input  bls_pkg::cmd_t               in_cmd,
	input  logic [bls_pkg::VALUE_W-1:0] in_value,
	input  logic [bls_pkg::POS_W-1:0]   in_position,
	input  logic [bls_pkg::LEN_W-1:0]   in_erase_length,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [bls_pkg::VALUE_W-1:0] out_read_value,
	output logic [bls_pkg::POS_W-1:0]   out_found_position,
	output bls_pkg::status_t            out_status,
	output logic [bls_pkg::COUNT_W-1:0] out_entry_count
);
	import bls_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int AW = ((CW > LEN_W + 1) ? CW : LEN_W + 1) + 1;

	logic [VALUE_WIDTH-1:0] mem [DEPTH];

	cmd_t                   cmd_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [POS_W-1:0]       pos_q;
	logic [LEN_W-1:0]       len_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          ptr_q;
	logic                   pend_q;
	logic [CW-1:0]          pend_idx_q;
	logic [VALUE_WIDTH-1:0] rd_data_q;
	logic [VALUE_W-1:0]     rv_q;
	logic [POS_W-1:0]       fp_q;
	status_t                st_q;
	logic                   out_valid_q;
	logic [VALUE_W-1:0]     out_rv_q;
	logic [POS_W-1:0]       out_fp_q;
	status_t                out_st_q;
	logic [COUNT_W-1:0]     out_cnt_q;

	logic [CW-1:0]          cnt_m1;
	logic [CW-1:0]          dst;
	logic [AW-1:0]          erase_end;
	logic                   ptr_lt;
	logic                   walk;
	logic                   rd_en;
	logic [IW-1:0]          rd_addr;
	logic                   wr_en;
	logic [IW-1:0]          wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;

	assign cnt_m1    = count_q - 1'b1;
	assign dst       = pend_idx_q - CW'(len_q);
	assign erase_end = AW'(pos_q) + AW'(len_q);
	assign ptr_lt    = ptr_q < count_q;
	assign walk      = ctrl.scan_run || ctrl.shift_run;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (ctrl.pop_rd) begin
			rd_en   = 1'b1;
			rd_addr = cnt_m1[IW-1:0];
		end else if (ctrl.pos_rd) begin
			rd_en   = 1'b1;
			rd_addr = IW'(pos_q);
		end else if (walk && ptr_lt) begin
			rd_en   = 1'b1;
			rd_addr = ptr_q[IW-1:0];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = val_q;
		if (ctrl.push_wr) begin
			wr_en   = 1'b1;
			wr_addr = count_q[IW-1:0];
		end else if (ctrl.shift_run && pend_q) begin
			wr_en   = 1'b1;
			wr_addr = dst[IW-1:0];
			wr_data = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Control state: count, walk tracking, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.push_wr) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.pop_rd) begin
				count_q <= cnt_m1;
			end else if (ctrl.cnt_to_pos) begin
				count_q <= CW'(pos_q);
			end else if (ctrl.cnt_to_chk) begin
				count_q <= pend_idx_q;
			end else if (ctrl.cnt_clear) begin
				count_q <= '0;
			end else if (ctrl.cnt_sub) begin
				count_q <= count_q - CW'(len_q);
			end

			if (ctrl.scan_init || ctrl.erase_init || ctrl.remove_init) begin
				pend_q <= 1'b0;
			end else if (walk) begin
				pend_q <= ptr_lt;
			end

			if (ctrl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (ctrl.load_in) begin
			cmd_q <= in_cmd;
			val_q <= VALUE_WIDTH'(in_value);
			pos_q <= in_position;
			len_q <= in_erase_length;
			rv_q  <= '0;
			fp_q  <= '0;
			st_q  <= ST_OK;
		end
		if (ctrl.remove_init) begin
			len_q <= LEN_W'(1);
		end
		if (ctrl.scan_init) begin
			ptr_q <= '0;
		end else if (ctrl.erase_init) begin
			ptr_q <= CW'(erase_end);
		end else if (ctrl.remove_init) begin
			ptr_q <= pend_idx_q + 1'b1;
		end else if (walk && ptr_lt) begin
			ptr_q      <= ptr_q + 1'b1;
			pend_idx_q <= ptr_q;
		end
		if (ctrl.take_rv) begin
			rv_q <= VALUE_W'(rd_data_q);
		end
		if (ctrl.take_fp) begin
			fp_q <= POS_W'(pend_idx_q);
		end
		if (ctrl.set_st) begin
			st_q <= ctrl.st;
		end
		if (ctrl.out_load) begin
			out_rv_q  <= rv_q;
			out_fp_q  <= fp_q;
			out_st_q  <= st_q;
			out_cnt_q <= COUNT_W'(count_q);
		end
	end

	always_comb begin
		stat.cmd        = cmd_q;
		stat.full       = count_q == CW'(DEPTH);
		stat.empty      = count_q == '0;
		stat.pos_in     = AW'(pos_q) < AW'(count_q);
		stat.erase_tail = erase_end >= AW'(count_q);
		stat.len_zero   = len_q == '0;
		stat.match      = pend_q && (rd_data_q == val_q);
		stat.match_last = pend_idx_q == cnt_m1;
		stat.walk_done  = !pend_q && !ptr_lt;
		stat.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid          = out_valid_q;
	assign out_read_value     = out_rv_q;
	assign out_found_position = out_fp_q;
	assign out_status         = out_st_q;
	assign out_entry_count    = out_cnt_q;

endmodule

// ===== rtl/core/bls_ctrl.sv =====
// Controller state machine of the bounded list store: decodes each command and
// sequences the datapath walks. Depends on bls_pkg.
module bls_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bls_pkg::bls_stat_t stat,
	output bls_pkg::bls_ctrl_t ctrl
);
	import bls_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.cmd)
					CMD_POP: begin
						state_d = stat.empty ? S_REPLY : S_RDWAIT;
					end
					CMD_READ: begin
						state_d = stat.pos_in ? S_RDWAIT : S_REPLY;
					end
					CMD_FIND, CMD_REMOVE: begin
						state_d = stat.empty ? S_REPLY : S_SCAN;
					end
					CMD_ERASE: begin
						if (stat.pos_in && !stat.erase_tail && !stat.len_zero) begin
							state_d = S_SHIFT;
						end else begin
							state_d = S_REPLY;
						end
					end
					default: begin
						state_d = S_REPLY;
					end
				endcase
			end
			S_RDWAIT: begin
				state_d = S_REPLY;
			end
			S_SCAN: begin
				if (stat.match) begin
					if (stat.cmd == CMD_REMOVE && !stat.match_last) begin
						state_d = S_SHIFT;
					end else begin
						state_d = S_REPLY;
					end
				end else if (stat.walk_done) begin
					state_d = S_REPLY;
				end
			end
			S_SHIFT: begin
				if (stat.walk_done) begin
					state_d = S_REPLY;
				end
			end
			S_REPLY: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl     = '0;
		ctrl.st  = ST_OK;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready     = 1'b1;
				ctrl.load_in = in_valid;
			end
			S_DECODE: begin
				case (stat.cmd)
					CMD_PUSH: begin
						if (stat.full) begin
							ctrl.set_st = 1'b1;
							ctrl.st     = ST_FULL;
						end else begin
							ctrl.push_wr = 1'b1;
						end
					end
					CMD_POP: begin
						if (stat.empty) begin
							ctrl.set_st = 1'b1;
							ctrl.st     = ST_EMPTY;
						end else begin
							ctrl.pop_rd = 1'b1;
						end
					end
					CMD_READ: begin
						if (stat.pos_in) begin
							ctrl.pos_rd = 1'b1;
						end else begin
							ctrl.set_st = 1'b1;
							ctrl.st     = ST_NOT_FOUND;
						end
					end
					CMD_FIND, CMD_REMOVE: begin
						if (stat.empty) begin
							ctrl.set_st = 1'b1;
							ctrl.st     = ST_NOT_FOUND;
						end else begin
							ctrl.scan_init = 1'b1;
						end
					end
					CMD_ERASE: begin
						if (!stat.pos_in) begin
							ctrl.set_st = 1'b1;
							ctrl.st     = ST_NOT_FOUND;
						end else if (stat.erase_tail) begin
							ctrl.cnt_to_pos = 1'b1;
						end else if (!stat.len_zero) begin
							ctrl.erase_init = 1'b1;
						end
					end
					CMD_CLEAR: begin
						ctrl.cnt_clear = 1'b1;
					end
					default: begin
						ctrl.set_st = 1'b1;
						ctrl.st     = ST_NOT_FOUND;
					end
				endcase
			end
			S_RDWAIT: begin
				ctrl.take_rv = 1'b1;
			end
			S_SCAN: begin
				if (stat.match) begin
					if (stat.cmd != CMD_REMOVE) begin
						ctrl.take_fp = 1'b1;
					end else if (stat.match_last) begin
						ctrl.cnt_to_chk = 1'b1;
					end else begin
						ctrl.remove_init = 1'b1;
					end
				end else if (stat.walk_done) begin
					ctrl.set_st = 1'b1;
					ctrl.st     = ST_NOT_FOUND;
				end else begin
					ctrl.scan_run = 1'b1;
				end
			end
			S_SHIFT: begin
				if (stat.walk_done) begin
					ctrl.cnt_sub = 1'b1;
				end else begin
					ctrl.shift_run = 1'b1;
				end
			end
			S_REPLY: begin
				ctrl.out_load = stat.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule
